/* hw/rtl/rsrd_pkg.sv */
`default_nettype none

package rsrd_pkg;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD  = 3'd1,
        PH_OLD   = 3'd2,
        PH_CODE  = 3'd3,
        PH_RUN   = 3'd4,
        PH_LIT   = 3'd5,
        PH_SKIP  = 3'd6
    } phase_t;

    // One write span, with its valid flag
    typedef struct packed {
        logic        valid;
        logic [15:0] start_pixel;
        logic [15:0] span_count;
        logic [2:0]  lane;
        logic [31:0] pixel_value;
        logic        row_done;
        logic        overrun;
    } span_t;

    localparam logic [15:0] MIN_PLANAR_WIDTH = 16'd8;
    localparam logic [15:0] MAX_PLANAR_WIDTH = 16'h7fff;
    localparam logic [7:0]  HEADER_MARK      = 8'd2;
    localparam logic [7:0]  RUN_FLAG         = 8'd128;
    localparam logic [23:0] REPEAT_MARK      = 24'h010101;
    localparam logic [2:0]  LANE_PACKED      = 3'd4;
    localparam logic [1:0]  LANE_EXP         = 2'd3;
    localparam logic [1:0]  GATHER_FULL      = 2'd3;
    localparam logic [1:0]  SHIFT_MAX        = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/rsrd_core.sv */
`default_nettype none

module rsrd_core
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic [15:0]     line_width,
    output rsrd_pkg::span_t      span
);

    rsrd_pkg::phase_t phase_reg, phase_next;
    logic [23:0] gathered_reg, gathered_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  chan_reg, chan_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  rem_reg, rem_next;
    logic [31:0] prev_reg, prev_next;
    logic [1:0]  shift_reg, shift_next;

    logic [15:0] width;
    logic [31:0] pix;
    logic        is_repeat;
    logic [15:0] rep_cnt;
    logic        header_bad;

    // span request
    logic        span_do;
    logic [15:0] span_want;
    logic [2:0]  span_lane;
    logic [31:0] span_val;
    logic        span_last;
    logic        span_extra;

    // span placement
    logic [15:0] avail;
    logic [15:0] span_n;
    logic [16:0] span_end;
    logic        ended;
    logic [7:0]  rem_dec;

    assign width      = (line_width == 16'd0) ? 16'd1 : line_width;
    assign pix        = {gathered_reg, data_byte};
    assign is_repeat  = (pix[31:8] == rsrd_pkg::REPEAT_MARK);
    assign header_bad = (gathered_reg[15:8] != rsrd_pkg::HEADER_MARK) || gathered_reg[7];
    assign rem_dec    = (rem_reg != 8'd0) ? rem_reg - 8'd1 : 8'd0;

    // repeat count, saturated at 16 bits
    always_comb
    begin
        case (shift_reg)
            2'd0:    rep_cnt = {8'd0, data_byte};
            2'd1:    rep_cnt = {data_byte, 8'd0};
            default: rep_cnt = (data_byte != 8'd0) ? 16'hffff : 16'd0;
        endcase
    end

    // select the span this byte asks for
    always_comb
    begin
        span_do    = 1'b0;
        span_want  = 16'd1;
        span_lane  = {1'b0, chan_reg};
        span_val   = {24'd0, data_byte};
        span_last  = (chan_reg == rsrd_pkg::LANE_EXP);
        span_extra = 1'b0;
        case (phase_reg)
            rsrd_pkg::PH_HEAD, rsrd_pkg::PH_OLD:
            begin
                if (count_reg == rsrd_pkg::GATHER_FULL &&
                    (phase_reg == rsrd_pkg::PH_OLD || header_bad))
                begin
                    span_do   = !is_repeat || (rep_cnt != 16'd0);
                    span_want = is_repeat ? rep_cnt : 16'd1;
                    span_lane = rsrd_pkg::LANE_PACKED;
                    span_val  = is_repeat ? prev_reg : pix;
                    span_last = 1'b1;
                end
            end
            rsrd_pkg::PH_RUN:
            begin
                span_do   = 1'b1;
                span_want = {8'd0, rem_reg};
            end
            rsrd_pkg::PH_LIT:
            begin
                span_do    = 1'b1;
                span_extra = (rem_reg > 8'd1);
            end
            default:
            begin
                span_do = 1'b0;
            end
        endcase
    end

    // clip the span to the line
    assign avail    = (pos_reg < width) ? width - pos_reg : 16'd0;
    assign span_n   = (span_want > avail) ? avail : span_want;
    assign span_end = {1'b0, pos_reg} + {1'b0, span_n};
    assign ended    = (span_end >= {1'b0, width});

    always_comb
    begin
        span.valid       = span_do && (span_n != 16'd0);
        span.start_pixel = pos_reg;
        span.span_count  = span_n;
        span.lane        = span_lane;
        span.pixel_value = span_val;
        span.row_done    = ended && span_last;
        span.overrun     = (span_want > span_n) || (ended && span_extra);
    end

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        gathered_next = gathered_reg;
        count_next    = count_reg;
        chan_next     = chan_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        prev_next     = prev_reg;
        shift_next    = shift_reg;
        case (phase_reg)
            rsrd_pkg::PH_HEAD0:
            begin
                pos_next      = 16'd0;
                chan_next     = 2'd0;
                shift_next    = 2'd0;
                gathered_next = {16'd0, data_byte};
                count_next    = 2'd1;
                if (width < rsrd_pkg::MIN_PLANAR_WIDTH || width > rsrd_pkg::MAX_PLANAR_WIDTH ||
                    data_byte != rsrd_pkg::HEADER_MARK)
                    phase_next = rsrd_pkg::PH_OLD;
                else
                    phase_next = rsrd_pkg::PH_HEAD;
            end
            rsrd_pkg::PH_HEAD, rsrd_pkg::PH_OLD:
            begin
                if (count_reg != rsrd_pkg::GATHER_FULL)
                begin
                    gathered_next = {gathered_reg[15:0], data_byte};
                    count_next    = count_reg + 2'd1;
                end
                else
                begin
                    gathered_next = 24'd0;
                    count_next    = 2'd0;
                    if (phase_reg == rsrd_pkg::PH_HEAD && !header_bad)
                    begin
                        // valid planar header
                        chan_next  = 2'd0;
                        pos_next   = 16'd0;
                        rem_next   = 8'd0;
                        phase_next = rsrd_pkg::PH_CODE;
                    end
                    else
                    begin
                        phase_next = rsrd_pkg::PH_OLD;
                        if (is_repeat)
                        begin
                            if (shift_reg != rsrd_pkg::SHIFT_MAX)
                                shift_next = shift_reg + 2'd1;
                        end
                        else
                        begin
                            shift_next = 2'd0;
                            prev_next  = pix;
                        end
                        if (span_do)
                        begin
                            pos_next = span_end[15:0];
                            if (ended)
                            begin
                                pos_next   = 16'd0;
                                shift_next = 2'd0;
                                phase_next = rsrd_pkg::PH_HEAD0;
                            end
                        end
                    end
                end
            end
            rsrd_pkg::PH_CODE:
            begin
                if (data_byte > rsrd_pkg::RUN_FLAG)
                begin
                    rem_next   = {1'b0, data_byte[6:0]};
                    phase_next = rsrd_pkg::PH_RUN;
                end
                else if (data_byte != 8'd0)
                begin
                    rem_next   = data_byte;
                    phase_next = rsrd_pkg::PH_LIT;
                end
            end
            rsrd_pkg::PH_RUN, rsrd_pkg::PH_LIT:
            begin
                rem_next = (phase_reg == rsrd_pkg::PH_RUN) ? 8'd0 : rem_dec;
                pos_next = span_end[15:0];
                if (ended)
                begin
                    // channel full: move to next channel or next line
                    pos_next = 16'd0;
                    if (chan_reg == rsrd_pkg::LANE_EXP)
                    begin
                        chan_next  = 2'd0;
                        phase_next = rsrd_pkg::PH_HEAD0;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 2'd1;
                        phase_next = rsrd_pkg::PH_CODE;
                    end
                    if (rem_next != 8'd0)
                        phase_next = rsrd_pkg::PH_SKIP;
                end
                else if (rem_next == 8'd0)
                begin
                    phase_next = rsrd_pkg::PH_CODE;
                end
            end
            rsrd_pkg::PH_SKIP:
            begin
                rem_next = rem_dec;
                if (rem_dec == 8'd0)
                    phase_next = (chan_reg == 2'd0) ? rsrd_pkg::PH_HEAD0 : rsrd_pkg::PH_CODE;
            end
            default:
            begin
                phase_next = rsrd_pkg::PH_HEAD0;
            end
        endcase
    end

    // state registers, updated once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= rsrd_pkg::PH_HEAD0;
            gathered_reg <= 24'd0;
            count_reg    <= 2'd0;
            chan_reg     <= 2'd0;
            pos_reg      <= 16'd0;
            rem_reg      <= 8'd0;
            prev_reg     <= 32'd0;
            shift_reg    <= 2'd0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            gathered_reg <= gathered_next;
            count_reg    <= count_next;
            chan_reg     <= chan_next;
            pos_reg      <= pos_next;
            rem_reg      <= rem_next;
            prev_reg     <= prev_next;
            shift_reg    <= shift_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rgbe_scanline_rle_decoder.sv */
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    data_byte
// output    out_valid/out_ready  start_pixel, span_count, lane, pixel_value, row_done, overrun
// config    cfg_wr_en            cfg_wr_data (line_width)
//
// One byte per cycle sustained while the output is not stalled. A byte is held in the input register,
// is decoded by the core logic and its span (if any) lands in the output register.
// Reset puts the decoder at the start of a scanline with line_width = 1.
// A stalled output holds the output register and a full input register; in_ready drops only when both are full.

module rgbe_scanline_rle_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      start_pixel,
    output logic [15:0]      span_count,
    output logic [2:0]       lane,
    output logic [31:0]      pixel_value,
    output logic             row_done,
    output logic             overrun
);

    logic [15:0]     width_reg;
    logic            in_valid_reg;
    logic [7:0]      byte_reg;
    logic            out_valid_reg;
    rsrd_pkg::span_t span;
    rsrd_pkg::span_t out_reg;
    logic            advance;
    logic            consume;

    // pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign consume  = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= 16'd1;
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= data_byte;
    end

    rsrd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (consume),
        .data_byte  (byte_reg),
        .line_width (width_reg),
        .span       (span)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= consume && span.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= span;
    end

    assign out_valid   = out_valid_reg;
    assign start_pixel = out_reg.start_pixel;
    assign span_count  = out_reg.span_count;
    assign lane        = out_reg.lane;
    assign pixel_value = out_reg.pixel_value;
    assign row_done    = out_reg.row_done;
    assign overrun     = out_reg.overrun;

endmodule

`default_nettype wire
